// ===== design/pst_pkg.sv =====
// Shared types and constants for the pot soft-takeover block.
package pst_pkg;

    localparam int POT_IDX_W   = 2;
    localparam int SAMPLE_W    = 8;
    localparam int POS_W       = 7;
    localparam int GRP_CFG_W   = 4;
    localparam int MEM_W       = POS_W + 1;   // {direction, value}
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SAMPLE_W-1:0] RAW_BYPASS = 8'd127;

    // Register index, taken from paddr[2]
    localparam logic REG_GRP_SEL = 1'b0;

    typedef struct packed {
        logic new_data;
        logic direction_up;
        logic hooked;
        logic [POS_W-1:0] group_value;
        logic [POS_W-1:0] position;
    } t_result;

    typedef struct packed {
        logic accept;
        logic fill_wr;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_req;
        logic fill_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== design/pst_ctrl.sv =====
// Sequencer for the pot soft-takeover block: accept, group fill, result emit.
module pst_ctrl
    import pst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_sts.fill_req ? ST_FILL : ST_EMIT;
                end
            end
            ST_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/pst_datapath.sv =====
// Datapath: pot position/hook registers, group value memory, takeover logic, output register.
module pst_datapath
    import pst_pkg::*;
#(
    parameter int NUM_POTS   = 4,
    parameter int NUM_GROUPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [POT_IDX_W-1:0]  i_pot,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_first,
    input  logic [(NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1)-1:0] i_grp,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_result               o_out
);

    localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PW    = (NUM_POTS > 1) ? $clog2(NUM_POTS) : 1;
    localparam int DEPTH = NUM_POTS * NUM_GROUPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // group value memory, {direction, value}
    logic [MEM_W-1:0] r_mem [DEPTH];
    logic [MEM_W-1:0] r_rd_data;

    logic [POS_W-1:0] r_pos  [NUM_POTS];
    logic             r_hook [NUM_POTS];

    logic [POT_IDX_W-1:0] r_pot;
    logic [SAMPLE_W-1:0]  r_raw;
    logic                 r_first;
    logic [AW-1:0]        r_base;
    logic [AW-1:0]        r_slot;
    logic [GW-1:0]        r_fill_cnt;

    logic                 r_out_valid;
    t_result              r_out;

    logic [AW-1:0]        base_in;
    logic [AW-1:0]        slot_in;
    logic                 in_range_in;
    logic                 in_range;
    logic [PW-1:0]        pidx;
    logic [POS_W-1:0]     old_pos;
    logic                 old_hook;
    logic [POS_W-1:0]     cur;
    logic [SAMPLE_W:0]    avg_sum;
    logic [POS_W-1:0]     cc;
    logic                 dir_mem;
    logic                 changed;
    logic                 prev_dir;
    logic                 new_dir;
    logic                 hook_n;
    logic [POS_W-1:0]     gv_n;
    logic                 dir_n;
    logic                 upd_we;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;
    logic                 out_free;
    t_result              res;

    // incoming request decode
    assign in_range_in = (32'(i_pot) < NUM_POTS);
    assign base_in     = AW'(int'(i_pot) * NUM_GROUPS);
    assign slot_in     = base_in + AW'(i_grp);

    // latched request
    assign in_range = (32'(r_pot) < NUM_POTS);
    assign pidx     = PW'(r_pot);
    assign old_pos  = r_pos[pidx];
    assign old_hook = r_hook[pidx];
    assign cc       = r_rd_data[POS_W-1:0];
    assign dir_mem  = r_rd_data[POS_W];

    // average with stored position unless bypass value or first pass
    assign avg_sum = {1'b0, SAMPLE_W'(old_pos)} + {1'b0, r_raw};
    assign cur     = (r_first || r_raw == RAW_BYPASS) ? r_raw[POS_W-1:0]
                                                      : avg_sum[POS_W:1];
    assign changed = !r_first && (cur != old_pos);

    assign prev_dir = (old_pos > cc);
    assign new_dir  = (cur > cc);

    always_comb begin
        hook_n = old_hook;
        gv_n   = cc;
        dir_n  = dir_mem;
        upd_we = 1'b0;
        if (old_hook) begin
            if (old_pos != cc) begin
                hook_n = 1'b0;
            end else begin
                gv_n   = cur;
                dir_n  = 1'b0;
                upd_we = 1'b1;
            end
        end else begin
            if (cur == cc) begin
                hook_n = 1'b1;
            end
            if (new_dir != prev_dir) begin
                hook_n = 1'b1;
                gv_n   = cur;
            end
            dir_n  = new_dir;
            upd_we = 1'b1;
        end
    end

    always_comb begin
        res = '0;
        if (!in_range) begin
            res = '0;
        end else if (r_first) begin
            res.position    = cur;
            res.group_value = cur;
            res.hooked      = 1'b1;
        end else if (changed) begin
            res.position     = cur;
            res.group_value  = gv_n;
            res.hooked       = hook_n;
            res.direction_up = hook_n ? 1'b0 : dir_n;
            res.new_data     = 1'b1;
        end else begin
            res.position     = old_pos;
            res.group_value  = cc;
            res.hooked       = old_hook;
            res.direction_up = old_hook ? 1'b0 : dir_mem;
        end
    end

    // memory write: group sweep on first pass, one slot on a changed step
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = {dir_n, gv_n};
        if (i_cmd.fill_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_base + AW'(r_fill_cnt);
            mem_wdata = {1'b0, cur};
        end else if (i_cmd.emit && in_range && changed && upd_we) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[slot_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pot   <= i_pot;
            r_raw   <= i_sample;
            r_first <= i_first;
            r_base  <= base_in;
            r_slot  <= slot_in;
        end
        if (i_cmd.emit && in_range && (r_first || changed)) begin
            r_pos[pidx]  <= cur;
            r_hook[pidx] <= r_first ? 1'b1 : hook_n;
        end
        if (i_cmd.emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_fill_cnt <= '0;
            end else if (i_cmd.fill_wr) begin
                r_fill_cnt <= r_fill_cnt + GW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.fill_req  = i_first && in_range_in;
    assign o_sts.fill_last = (r_fill_cnt == GW'(NUM_GROUPS - 1));
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== design/pot_soft_takeover.sv =====
// Top level of the pot soft-takeover block: stream ports, config register, core wiring.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready         tdata: pot_index, sample; tuser: first_pass
//  m_axis    out  m_axis_tvalid/tready         tdata: position, group_value, hooked,
//                                                     direction_up, new_data
//  apb       in   psel/penable/pwrite/pready   reg 0 at 0x0: group select [3:0]
//
// Steps: a normal sample is accepted with a memory read, then evaluated,
// written back and emitted; a first-pass sample adds a fill step between them,
// in which the single write port of the group value memory sweeps every group.
// One request is in flight at a time; s_axis_tready is high only when idle.
// Reset (synchronous, active low) clears the sequencer, the output valid and
// the group select; pot and group stores hold garbage until a first pass loads them.
// A stalled result sits in the output register; the next request is accepted
// meanwhile and waits in the emit step until the register frees up.
module pot_soft_takeover
    import pst_pkg::*;
#(
    parameter int NUM_POTS   = 4,
    parameter int NUM_GROUPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [1:0] pot_index, [9:2] sample, rest 0
    input  logic                   s_axis_tuser,   // [0] first_pass
    // master stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [6:0] position, [13:7] group_value,
                                                   // [14] hooked, [15] direction_up,
                                                   // [16] new_data, rest 0
    // config port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int NUM_CFG_GRP = 2 ** GRP_CFG_W;

    // group select wraps modulo NUM_GROUPS; folded into a table at elaboration
    function automatic logic [NUM_CFG_GRP-1:0][GW-1:0] f_grp_lut();
        logic [NUM_CFG_GRP-1:0][GW-1:0] lut;
        for (int i = 0; i < NUM_CFG_GRP; i++) begin
            lut[i] = GW'(i % NUM_GROUPS);
        end
        return lut;
    endfunction

    localparam logic [NUM_CFG_GRP-1:0][GW-1:0] GRP_LUT = f_grp_lut();

    logic [GRP_CFG_W-1:0] r_grp_sel;
    logic                 cfg_wr;
    logic                 in_ready;
    logic                 out_valid;
    t_result              out_res;
    t_dp_cmd              cmd;
    t_dp_sts              sts;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_sel <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_GRP_SEL: r_grp_sel <= pwdata[GRP_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GRP_SEL: prdata = CFG_DATA_W'(r_grp_sel);
            default:     prdata = '0;
        endcase
    end

    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pst_datapath #(
        .NUM_POTS   (NUM_POTS),
        .NUM_GROUPS (NUM_GROUPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pot       (s_axis_tdata[POT_IDX_W-1:0]),
        .i_sample    (s_axis_tdata[POT_IDX_W +: SAMPLE_W]),
        .i_first     (s_axis_tuser),
        .i_grp       (GRP_LUT[r_grp_sel]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (out_valid),
        .o_out       (out_res)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(out_res);

endmodule

// ===== design/pst_checker.sv =====
// Port-level checker for pot_soft_takeover, bound to the top level.
module pst_checker
    import pst_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   pready
);

    localparam int HOOKED_IDX = 2 * POS_W;
    localparam int DIR_BIT    = 2 * POS_W + 1;
    localparam int RES_W      = 2 * POS_W + 3;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request in flight: ready drops after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    // a hooked pot never reports a direction
    a_hook_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[HOOKED_IDX] |-> !m_axis_tdata[DIR_BIT])
        else $error("direction set on hooked pot");

    // padding stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:RES_W] == '0)
        else $error("nonzero padding in result");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind pot_soft_takeover pst_checker u_pst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

// ===== tb/pot_soft_takeover_tb.sv =====
// Self-checking testbench for pot_soft_takeover: directed and random samples, group switching.
module pot_soft_takeover_tb;
    import pst_pkg::*;

    localparam int NUM_POTS   = 4;
    localparam int NUM_GROUPS = 16;
    localparam int MAX_WAIT   = 19;
    localparam int REPORT_MAX = 10;
    localparam int RAND_PHASES    = 34;
    localparam int ITEMS_PER_PHASE = 50;

    // One sample request on the input stream
    typedef struct {
        logic [POT_IDX_W-1:0] pot;
        logic [SAMPLE_W-1:0]  sample;
        logic                 first;
    } t_pot_sample;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [1:0] pot_index, [9:2] sample, rest 0
    logic                   s_axis_tuser = 1'b0; // [0] first_pass
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [6:0] position, [13:7] group_value,
                                                 // [14] hooked, [15] direction_up,
                                                 // [16] new_data, rest 0
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    pot_soft_takeover #(
        .NUM_POTS   (NUM_POTS),
        .NUM_GROUPS (NUM_GROUPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block state, advanced once per accepted request
    // ------------------------------------------------------------------
    logic [POS_W-1:0]     pos_mem  [NUM_POTS];
    logic                 hook_mem [NUM_POTS];
    logic [POS_W-1:0]     grp_val  [NUM_POTS][NUM_GROUPS];
    logic                 grp_dir  [NUM_POTS][NUM_GROUPS];
    logic [GRP_CFG_W-1:0] sel_group = '0;

    t_pot_sample pending_samples[$];
    t_result     expected_pot_states[$];
    int          bad_fields = 0;

    function automatic t_result advance_takeover(t_pot_sample r);
        logic [POT_IDX_W-1:0] p;
        logic [POS_W-1:0]     prev_pos;
        logic [POS_W-1:0]     next_pos;
        logic [POS_W-1:0]     gv;
        logic [8:0]           sum;
        logic                 up_old;
        logic                 up_new;
        t_result              res;
        p        = r.pot;
        prev_pos = pos_mem[p];
        sum      = {2'b00, prev_pos} + {1'b0, r.sample};
        // bypass value and first pass take the raw sample, else average
        if (r.first || r.sample == RAW_BYPASS)
            next_pos = r.sample[POS_W-1:0];
        else
            next_pos = sum[POS_W:1];
        res = '0;
        if (r.first) begin
            pos_mem[p]  = next_pos;
            hook_mem[p] = 1'b1;
            for (int i = 0; i < NUM_GROUPS; i++) begin
                grp_val[p][i] = next_pos;
                grp_dir[p][i] = 1'b0;
            end
        end else if (next_pos != prev_pos) begin
            gv = grp_val[p][sel_group];
            res.new_data = 1'b1;
            if (!hook_mem[p]) begin
                // pick up on reaching or crossing the stored value
                up_old = prev_pos > gv;
                up_new = next_pos > gv;
                if (next_pos == gv)
                    hook_mem[p] = 1'b1;
                if (up_new != up_old) begin
                    hook_mem[p] = 1'b1;
                    grp_val[p][sel_group] = next_pos;
                end
                grp_dir[p][sel_group] = up_new;
            end else if (prev_pos != gv) begin
                hook_mem[p] = 1'b0;
            end else begin
                grp_val[p][sel_group] = next_pos;
                grp_dir[p][sel_group] = 1'b0;
            end
            pos_mem[p] = next_pos;
        end
        res.position     = pos_mem[p];
        res.group_value  = grp_val[p][sel_group];
        res.hooked       = hook_mem[p];
        res.direction_up = hook_mem[p] ? 1'b0 : grp_dir[p][sel_group];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one request at a time from pending_samples
    // ------------------------------------------------------------------
    t_pot_sample in_flight;
    int          src_wait = 0;
    logic        src_calm = 1'b0;
    logic        vld_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            vld_next = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_pot_states.push_back(advance_takeover(in_flight));
                vld_next = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    src_calm = !src_calm;
                src_wait = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!vld_next) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (pending_samples.size() != 0) begin
                    in_flight     = pending_samples.pop_front();
                    vld_next      = 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'({in_flight.sample, in_flight.pot});
                    s_axis_tuser  <= in_flight.first;
                end
            end
            s_axis_tvalid <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compare each result with the oldest prediction
    // ------------------------------------------------------------------
    int      sink_wait = 0;
    logic    sink_calm = 1'b0;
    logic    rdy_next;
    t_result got;
    t_result want;

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            bad_fields++;
            if (bad_fields <= REPORT_MAX)
                $display("%0t: %s expected %0d, got %0d", $realtime, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (expected_pot_states.size() == 0) begin
                    bad_fields++;
                    if (bad_fields <= REPORT_MAX)
                        $display("%0t: result with none expected, tdata 0x%h",
                                 $realtime, m_axis_tdata);
                end else begin
                    want = expected_pot_states.pop_front();
                    check_field("position", want.position, got.position);
                    check_field("group_value", want.group_value, got.group_value);
                    check_field("hooked", want.hooked, got.hooked);
                    check_field("direction_up", want.direction_up, got.direction_up);
                    check_field("new_data", want.new_data, got.new_data);
                end
                if ($urandom_range(0, 39) == 0)
                    sink_calm = !sink_calm;
                sink_wait = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                rdy_next = 1'b0;
            end else begin
                rdy_next = 1'b1;
            end
            m_axis_tready <= rdy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_sample(int pot, int sample, bit first);
        t_pot_sample r;
        r.pot    = POT_IDX_W'(pot);
        r.sample = SAMPLE_W'(sample);
        r.first  = first;
        pending_samples.push_back(r);
    endtask

    // Wait for every request to come back, then write the group select over APB
    task automatic drain_and_select_group(logic [GRP_CFG_W-1:0] g);
        while (pending_samples.size() != 0 || s_axis_tvalid ||
               expected_pot_states.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * REG_GRP_SEL);
        pwdata  <= {28'($urandom()), g};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sel_group = g;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    int pick;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bring every pot up first, then walk through the takeover cases
        drain_and_select_group(4'd0);
        push_sample(0, 8'h00, 1);
        push_sample(1, 8'hFF, 1);
        push_sample(2, RAW_BYPASS, 1);
        push_sample(3, 8'h80, 1);
        push_sample(1, RAW_BYPASS, 0);   // bypass, position unchanged
        push_sample(0, 8'h00, 0);        // unchanged
        push_sample(0, 8'hFF, 0);        // hooked, drags value up
        push_sample(0, 8'h00, 0);        // hooked, drags value down
        push_sample(3, 8'hFF, 0);
        push_sample(2, 64, 1);           // re-init pot 2 mid-run
        push_sample(2, 8'h00, 0);

        drain_and_select_group(4'd15);
        push_sample(0, 8'hFF, 0);        // hooked but off the stored value: unhook
        repeat (5) push_sample(0, 8'h00, 0);   // settles onto stored value: hook
        push_sample(2, 40, 0);           // unhook below stored value
        push_sample(2, RAW_BYPASS, 0);   // jumps across it: hook and take over
        push_sample(3, 8'h00, 0);

        // Random: each phase runs under a group selection written at its start
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_and_select_group(ph == 0 ? 4'd15 : ph == 1 ? 4'd0 :
                                   GRP_CFG_W'($urandom_range(0, NUM_GROUPS - 1)));
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    push_sample($urandom_range(0, NUM_POTS - 1), $urandom_range(0, 255), 1);
                else if (pick < 13)
                    push_sample($urandom_range(0, NUM_POTS - 1), RAW_BYPASS, 0);
                else if (pick < 55)
                    push_sample($urandom_range(0, NUM_POTS - 1), $urandom_range(0, 127), 0);
                else
                    push_sample($urandom_range(0, NUM_POTS - 1), $urandom_range(0, 255), 0);
            end
        end

        while (pending_samples.size() != 0 || s_axis_tvalid ||
               expected_pot_states.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (bad_fields == 0 && expected_pot_states.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hang guard, several times the slowest legal run
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
